### hdl/pid_position_delta_step_macros.svh
// Assertion macros shared by the checker of the PID step block.
`ifndef PID_POSITION_DELTA_STEP_MACROS_SVH
`define PID_POSITION_DELTA_STEP_MACROS_SVH

// Same-cycle implication sampled on clk and disabled while arst_n is low.
// The scope that uses this macro must have clk and arst_n.
`define PIDPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication sampled on clk and disabled while arst_n is low.
`define PIDPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pidpd_pkg.sv
// Types, constants and saturating arithmetic helpers for the PID step block.
package pidpd_pkg;

	localparam int DW        = 32;          // data word width, signed fixed point
	localparam int FRAC      = 16;          // fraction bits of the fixed-point format
	localparam int WIDE      = DW + 4;      // headroom for sums of a few words
	localparam int PW        = 2 * DW;      // full product width
	localparam int NLANE     = 3;           // proportional, integral, derivative
	localparam int REG_IDX_W = 3;

	localparam int LANE_P = 0;
	localparam int LANE_I = 1;
	localparam int LANE_D = 2;

	localparam logic [DW-2:0] LIMIT_MAX = '1;

	typedef enum logic [1:0] {
		ST_NORMAL    = 2'd0,
		ST_ERR_LIMIT = 2'd1,
		ST_DEAD_ZONE = 2'd2,
		ST_CLEARED   = 2'd3
	} status_t;

	typedef enum logic {
		MODE_POS = 1'b0,
		MODE_INC = 1'b1
	} mode_t;

	typedef enum logic {
		ACT_STEP  = 1'b0,
		ACT_CLEAR = 1'b1
	} action_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE           = 3'd0,
		REG_GAIN_P         = 3'd1,
		REG_GAIN_I         = 3'd2,
		REG_GAIN_D         = 3'd3,
		REG_OUTPUT_LIMIT   = 3'd4,
		REG_INTEGRAL_LIMIT = 3'd5,
		REG_ERROR_LIMIT    = 3'd6,
		REG_DEAD_ZONE      = 3'd7
	} reg_idx_t;

	// Control that travels alongside a word through the pipeline.
	typedef struct packed {
		logic    vld;
		status_t st;
	} ctl_t;

	// Saturate a wide signed value to one data word.
	function automatic logic signed [DW-1:0] sat_wide(input logic signed [WIDE-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[WIDE-1:DW-1];
		hi_zeros = ~|v[WIDE-1:DW-1];
		if (v[WIDE-1] && !hi_ones) begin
			return {1'b1, {(DW-1){1'b0}}};
		end else if (!v[WIDE-1] && !hi_zeros) begin
			return {1'b0, {(DW-1){1'b1}}};
		end else begin
			return v[DW-1:0];
		end
	endfunction

	// Drop the fraction bits of a full product, rounding toward minus
	// infinity, and saturate to one data word.
	function automatic logic signed [DW-1:0] sat_prod(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] s;
		logic                 hi_ones;
		logic                 hi_zeros;
		s        = p >>> FRAC;
		hi_ones  = &s[PW-1:DW-1];
		hi_zeros = ~|s[PW-1:DW-1];
		if (s[PW-1] && !hi_ones) begin
			return {1'b1, {(DW-1){1'b0}}};
		end else if (!s[PW-1] && !hi_zeros) begin
			return {1'b0, {(DW-1){1'b1}}};
		end else begin
			return s[DW-1:0];
		end
	endfunction

	// Clamp a wide signed value to the range -lim .. +lim.
	function automatic logic signed [DW-1:0] clamp_abs(input logic signed [WIDE-1:0] v,
		input logic [DW-2:0] lim);
		logic signed [WIDE-1:0] lp;
		logic signed [WIDE-1:0] ln;
		lp = $signed(WIDE'(lim));
		ln = -lp;
		if (v > lp) begin
			return lp[DW-1:0];
		end else if (v < ln) begin
			return ln[DW-1:0];
		end else begin
			return v[DW-1:0];
		end
	endfunction

endpackage

### hdl/pidpd_mul.sv
// Three-lane gain multiplier: registered product, then registered rescale.
module pidpd_mul (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  pidpd_pkg::ctl_t                           ctl_in,
	input  logic signed [pidpd_pkg::DW-1:0]           gain [pidpd_pkg::NLANE],
	input  logic signed [pidpd_pkg::DW-1:0]           opnd [pidpd_pkg::NLANE],
	output pidpd_pkg::ctl_t                           ctl_out,
	output logic signed [pidpd_pkg::DW-1:0]           q    [pidpd_pkg::NLANE]
);

	localparam int PW = pidpd_pkg::PW;

	pidpd_pkg::ctl_t             ctl_s4;
	pidpd_pkg::ctl_t             ctl_s5;
	logic signed [PW-1:0]        prod_s4 [pidpd_pkg::NLANE];
	logic signed [pidpd_pkg::DW-1:0] q_s5 [pidpd_pkg::NLANE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '{vld: 1'b0, st: pidpd_pkg::ST_NORMAL};
			ctl_s5 <= '{vld: 1'b0, st: pidpd_pkg::ST_NORMAL};
		end else if (en) begin
			ctl_s4 <= ctl_in;
			ctl_s5 <= ctl_s4;
		end
	end

	// The full signed product is exact; the rescale is an arithmetic shift,
	// which rounds toward minus infinity.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < pidpd_pkg::NLANE; l++) begin
				prod_s4[l] <= PW'(gain[l]) * PW'(opnd[l]);
				q_s5[l]    <= pidpd_pkg::sat_prod(prod_s4[l]);
			end
		end
	end

	assign ctl_out = ctl_s5;
	assign q       = q_s5;

endmodule

### hdl/pid_position_delta_step.sv
// Top level of the PID step block: config registers, error stage, state loops and output.
//
// One PID controller step per input word, in signed Q16.16. Each word carries
// an action (step or clear), a measured value and a target; each word yields
// exactly one result word with the drive value and a status code (normal,
// error limit hit, inside the dead zone, cleared). The block takes a new word
// in every cycle while the result side does not stall, and is fully
// pipelined. A word goes through the stage chain: input register, error
// subtract and saturate, limit tests with the error history, the gain
// multipliers, the product rescale, the partial sums, the integral
// accumulator, and the output accumulator with the result register.
// Each piece of kept state (error history, integral, held output) is
// updated in a single stage of its own, so consecutive words see each
// other's updates with no wait. When the result side stalls, the whole
// pipeline freezes and a skid register catches the one word that may
// arrive meanwhile; item_ready is a registered signal. The eight
// configuration registers are written through a plain write port and
// must only change while no word is in flight.
module pid_position_delta_step (
	input  logic                                        clk,
	input  logic                                        arst_n,
	// configuration write port
	input  logic                                        cfg_wen,
	input  logic [pidpd_pkg::REG_IDX_W-1:0]             cfg_idx,
	input  logic [pidpd_pkg::DW-1:0]                    cfg_wdata,
	// input words
	input  logic                                        item_valid,
	output logic                                        item_ready,
	input  logic                                        action,
	input  logic signed [pidpd_pkg::DW-1:0]             measured,
	input  logic signed [pidpd_pkg::DW-1:0]             target,
	// result words
	output logic                                        result_valid,
	input  logic                                        result_ready,
	output logic signed [pidpd_pkg::DW-1:0]             drive,
	output logic [1:0]                                  status
);

	localparam int DW   = pidpd_pkg::DW;
	localparam int WIDE = pidpd_pkg::WIDE;

	// Configuration registers.
	pidpd_pkg::mode_t        mode_q;
	logic signed [DW-1:0]    gain_p_q;
	logic signed [DW-1:0]    gain_i_q;
	logic signed [DW-1:0]    gain_d_q;
	logic [DW-2:0]           olim_q;
	logic [DW-2:0]           ilim_q;
	logic [DW-2:0]           elim_q;
	logic [DW-2:0]           dzone_q;

	// Kept controller state.
	logic signed [DW-1:0]    last_q;
	logic signed [DW-1:0]    prior_q;
	logic signed [DW-1:0]    integral_q;
	logic signed [DW-1:0]    held_q;

	// Flow control.
	logic                    adv;
	logic                    pos;

	// Skid register in front of the pipeline.
	logic                    skid_vld_q;
	logic                    skid_act_q;
	logic signed [DW-1:0]    skid_meas_q;
	logic signed [DW-1:0]    skid_targ_q;
	logic                    src_vld;
	logic                    src_act;
	logic signed [DW-1:0]    src_meas;
	logic signed [DW-1:0]    src_targ;

	// Stage 1: input register.
	logic                    vld_s1;
	logic                    act_s1;
	logic signed [DW-1:0]    meas_s1;
	logic signed [DW-1:0]    targ_s1;

	// Stage 2: control error.
	logic signed [DW-1:0]    err_d;
	logic                    vld_s2;
	logic                    clr_s2;
	logic signed [DW-1:0]    e_s2;

	// Stage 3: limit tests and error differences.
	logic [DW-1:0]           abs_e;
	pidpd_pkg::status_t      st_d;
	logic signed [DW-1:0]    diff1;
	logic signed [DW-1:0]    diff2;
	pidpd_pkg::ctl_t         ctl_s3;
	logic signed [DW-1:0]    e_s3;
	logic signed [DW-1:0]    opp_s3;
	logic signed [DW-1:0]    opd_s3;

	// Stages 4 and 5: gain products.
	logic signed [DW-1:0]    mul_gain [pidpd_pkg::NLANE];
	logic signed [DW-1:0]    mul_opnd [pidpd_pkg::NLANE];
	pidpd_pkg::ctl_t         ctl_s5;
	logic signed [DW-1:0]    q_s5 [pidpd_pkg::NLANE];

	// Stage 6: partial sums.
	pidpd_pkg::ctl_t         ctl_s6;
	logic signed [WIDE-1:0]  pd_s6;
	logic signed [DW-1:0]    it_s6;
	logic signed [DW-1:0]    qi_s6;

	// Stage 7: integral accumulator.
	logic signed [DW-1:0]    int_acc;
	logic signed [DW-1:0]    int_new;
	logic signed [WIDE-1:0]  xsum;
	pidpd_pkg::ctl_t         ctl_s7;
	logic signed [WIDE-1:0]  x_s7;
	logic signed [DW-1:0]    i_s7;

	// Stage 8: output accumulator and result register.
	logic signed [WIDE-1:0]  out_acc;
	logic signed [DW-1:0]    held_new;
	logic                    result_vld_q;
	logic signed [DW-1:0]    drive_q;
	pidpd_pkg::status_t      status_q;

	// ------------------------------------------------------------------
	// Configuration port.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= pidpd_pkg::MODE_POS;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			olim_q   <= pidpd_pkg::LIMIT_MAX;
			ilim_q   <= pidpd_pkg::LIMIT_MAX;
			elim_q   <= '0;
			dzone_q  <= '0;
		end else if (cfg_wen) begin
			unique case (pidpd_pkg::reg_idx_t'(cfg_idx))
				pidpd_pkg::REG_MODE:           mode_q   <= pidpd_pkg::mode_t'(cfg_wdata[0]);
				pidpd_pkg::REG_GAIN_P:         gain_p_q <= cfg_wdata;
				pidpd_pkg::REG_GAIN_I:         gain_i_q <= cfg_wdata;
				pidpd_pkg::REG_GAIN_D:         gain_d_q <= cfg_wdata;
				pidpd_pkg::REG_OUTPUT_LIMIT:   olim_q   <= cfg_wdata[DW-2:0];
				pidpd_pkg::REG_INTEGRAL_LIMIT: ilim_q   <= cfg_wdata[DW-2:0];
				pidpd_pkg::REG_ERROR_LIMIT:    elim_q   <= cfg_wdata[DW-2:0];
				pidpd_pkg::REG_DEAD_ZONE:      dzone_q  <= cfg_wdata[DW-2:0];
			endcase
		end
	end

	assign pos = (mode_q == pidpd_pkg::MODE_POS);

	// The whole pipeline moves together; it only stops while a finished
	// result waits on the output register.
	assign adv        = !result_vld_q || result_ready;
	assign item_ready = !skid_vld_q;

	// A word held in the skid register always goes first. While it is full,
	// item_ready is low, so no word is taken from the port at the same time.
	assign src_vld  = skid_vld_q || item_valid;
	assign src_act  = skid_vld_q ? skid_act_q  : action;
	assign src_meas = skid_vld_q ? skid_meas_q : measured;
	assign src_targ = skid_vld_q ? skid_targ_q : target;

	// ------------------------------------------------------------------
	// Combinational logic of each stage.
	// ------------------------------------------------------------------
	assign err_d = pidpd_pkg::sat_wide(WIDE'(targ_s1) - WIDE'(meas_s1));

	assign abs_e = e_s2[DW-1] ? $unsigned(-e_s2) : $unsigned(e_s2);

	// The error limit test has priority over the dead zone test.
	always_comb begin
		if (clr_s2) begin
			st_d = pidpd_pkg::ST_CLEARED;
		end else if ((elim_q != '0) && (abs_e > DW'(elim_q))) begin
			st_d = pidpd_pkg::ST_ERR_LIMIT;
		end else if ((dzone_q != '0) && (abs_e < DW'(dzone_q))) begin
			st_d = pidpd_pkg::ST_DEAD_ZONE;
		end else begin
			st_d = pidpd_pkg::ST_NORMAL;
		end
	end

	// First and second differences of the error, each saturated before it
	// meets a gain.
	assign diff1 = pidpd_pkg::sat_wide(WIDE'(e_s2) - WIDE'(last_q));
	assign diff2 = pidpd_pkg::sat_wide(WIDE'(e_s2) - (WIDE'(last_q) <<< 1) + WIDE'(prior_q));

	// Positional form multiplies the error and its first difference;
	// incremental form multiplies the first and second differences.
	assign mul_gain[pidpd_pkg::LANE_P] = gain_p_q;
	assign mul_gain[pidpd_pkg::LANE_I] = gain_i_q;
	assign mul_gain[pidpd_pkg::LANE_D] = gain_d_q;
	assign mul_opnd[pidpd_pkg::LANE_P] = opp_s3;
	assign mul_opnd[pidpd_pkg::LANE_I] = e_s3;
	assign mul_opnd[pidpd_pkg::LANE_D] = opd_s3;

	pidpd_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ctl_in  (ctl_s3),
		.gain    (mul_gain),
		.opnd    (mul_opnd),
		.ctl_out (ctl_s5),
		.q       (q_s5)
	);

	// In positional form the integral accumulates and is clamped; in
	// incremental form it is just this step's clamped integral product.
	assign int_acc = pidpd_pkg::clamp_abs(WIDE'(integral_q) + WIDE'(qi_s6), ilim_q);
	assign int_new = pos ? int_acc : it_s6;
	assign xsum    = pos ? pd_s6 : (pd_s6 + WIDE'(it_s6));

	// Positional form sums the terms afresh; incremental form adds them to
	// the held output.
	assign out_acc  = x_s7 + WIDE'(pos ? i_s7 : held_q);
	assign held_new = pidpd_pkg::clamp_abs(out_acc, olim_q);

	// ------------------------------------------------------------------
	// Control registers and kept state.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q   <= 1'b0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			ctl_s3       <= '{vld: 1'b0, st: pidpd_pkg::ST_NORMAL};
			ctl_s6       <= '{vld: 1'b0, st: pidpd_pkg::ST_NORMAL};
			ctl_s7       <= '{vld: 1'b0, st: pidpd_pkg::ST_NORMAL};
			result_vld_q <= 1'b0;
			last_q       <= '0;
			prior_q      <= '0;
			integral_q   <= '0;
			held_q       <= '0;
		end else begin
			if (adv) begin
				skid_vld_q <= 1'b0;
			end else if (item_valid && item_ready) begin
				skid_vld_q <= 1'b1;
			end

			if (adv) begin
				vld_s1       <= src_vld;
				vld_s2       <= vld_s1;
				ctl_s3       <= '{vld: vld_s2, st: st_d};
				ctl_s6       <= ctl_s5;
				ctl_s7       <= ctl_s6;
				result_vld_q <= ctl_s7.vld;

				// A suppressed step leaves every piece of state alone.
				if (vld_s2) begin
					unique case (st_d)
						pidpd_pkg::ST_CLEARED: begin
							last_q  <= '0;
							prior_q <= '0;
						end
						pidpd_pkg::ST_NORMAL: begin
							last_q  <= e_s2;
							prior_q <= last_q;
						end
						pidpd_pkg::ST_ERR_LIMIT, pidpd_pkg::ST_DEAD_ZONE: begin
						end
					endcase
				end

				if (ctl_s6.vld) begin
					unique case (ctl_s6.st)
						pidpd_pkg::ST_CLEARED: begin
							integral_q <= '0;
						end
						pidpd_pkg::ST_NORMAL: begin
							integral_q <= int_new;
						end
						pidpd_pkg::ST_ERR_LIMIT, pidpd_pkg::ST_DEAD_ZONE: begin
						end
					endcase
				end

				if (ctl_s7.vld) begin
					unique case (ctl_s7.st)
						pidpd_pkg::ST_CLEARED: begin
							held_q <= '0;
						end
						pidpd_pkg::ST_NORMAL: begin
							held_q <= held_new;
						end
						pidpd_pkg::ST_ERR_LIMIT, pidpd_pkg::ST_DEAD_ZONE: begin
						end
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (!adv && item_valid && item_ready) begin
			skid_act_q  <= action;
			skid_meas_q <= measured;
			skid_targ_q <= target;
		end
		if (adv) begin
			act_s1   <= src_act;
			meas_s1  <= src_meas;
			targ_s1  <= src_targ;

			e_s2     <= err_d;
			clr_s2   <= (pidpd_pkg::action_t'(act_s1) == pidpd_pkg::ACT_CLEAR);

			e_s3     <= e_s2;
			opp_s3   <= pos ? e_s2  : diff1;
			opd_s3   <= pos ? diff1 : diff2;

			pd_s6    <= WIDE'(q_s5[pidpd_pkg::LANE_P]) + WIDE'(q_s5[pidpd_pkg::LANE_D]);
			it_s6    <= pidpd_pkg::clamp_abs(WIDE'(q_s5[pidpd_pkg::LANE_I]), ilim_q);
			qi_s6    <= q_s5[pidpd_pkg::LANE_I];

			x_s7     <= xsum;
			i_s7     <= int_new;

			drive_q  <= (ctl_s7.st == pidpd_pkg::ST_NORMAL) ? held_new : '0;
			status_q <= ctl_s7.st;
		end
	end

	assign result_valid = result_vld_q;
	assign drive        = drive_q;
	assign status       = status_q;

endmodule

### hdl/pidpd_chk.sv
// Port-level checker for the PID step block, bound to the top level.
`include "pid_position_delta_step_macros.svh"

module pidpd_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [pidpd_pkg::REG_IDX_W-1:0]     cfg_idx,
	input  logic [pidpd_pkg::DW-1:0]            cfg_wdata,
	input  logic                                item_valid,
	input  logic                                item_ready,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  logic signed [pidpd_pkg::DW-1:0]     drive,
	input  logic [1:0]                          status
);

	localparam int DW = pidpd_pkg::DW;

	logic [DW-2:0]        olim_q;
	logic signed [DW:0]   lim_pos;
	logic signed [DW:0]   drv_x;

	// Shadow copy of the output limit, taken from the write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olim_q <= pidpd_pkg::LIMIT_MAX;
		end else if (cfg_wen &&
			(pidpd_pkg::reg_idx_t'(cfg_idx) == pidpd_pkg::REG_OUTPUT_LIMIT)) begin
			olim_q <= cfg_wdata[DW-2:0];
		end
	end

	assign lim_pos = $signed({2'b00, olim_q});
	assign drv_x   = (DW+1)'(drive);

	`PIDPD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(drive) && $stable(status), "result word changed while stalled")
	`PIDPD_ASSERT_NOW(a_quiet_drive, result_valid && (status != 2'(pidpd_pkg::ST_NORMAL)), drive == '0, "suppressed or cleared word has nonzero drive")
	`PIDPD_ASSERT_NOW(a_drive_limit, result_valid && (status == 2'(pidpd_pkg::ST_NORMAL)), (drv_x <= lim_pos) && (drv_x >= -lim_pos), "drive outside the output limit")
	`PIDPD_ASSERT_NOW(a_ready_drop, $fell(item_ready), $past(item_valid) && $past(result_valid) && !$past(result_ready), "input ready dropped without a stalled word")

endmodule

bind pid_position_delta_step pidpd_chk u_pidpd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_wen      (cfg_wen),
	.cfg_idx      (cfg_idx),
	.cfg_wdata    (cfg_wdata),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.drive        (drive),
	.status       (status)
);

### tb/tb.sv
// Self-checking testbench for the PID step block: directed corners, random settings, back-pressure.
module tb;

	localparam int DW        = pidpd_pkg::DW;
	localparam int FRAC      = pidpd_pkg::FRAC;
	localparam int REG_IDX_W = pidpd_pkg::REG_IDX_W;

	// One result word as the block should deliver it.
	typedef struct packed {
		logic signed [DW-1:0] drive;
		pidpd_pkg::status_t   st;
	} outcome_t;

	localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] ONE  = 32'sh0001_0000;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	// Extra idle time after the last owed result, so the pipeline can settle.
	localparam int SETTLE_CYCLES = 10;
	localparam int REPORT_LIMIT  = 10;
	// Far above the slowest legal run, with every gap and stall.
	localparam int RUN_LIMIT = 2_000_000;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_wen;
	logic [REG_IDX_W-1:0]        cfg_idx;
	logic [DW-1:0]               cfg_wdata;
	logic                        item_valid;
	logic                        item_ready;
	logic                        action;
	logic signed [DW-1:0]        measured;
	logic signed [DW-1:0]        target;
	logic                        result_valid;
	logic                        result_ready;
	logic signed [DW-1:0]        drive;
	logic [1:0]                  status;

	// Settings as the controller should currently see them.
	pidpd_pkg::mode_t     cur_mode   = pidpd_pkg::MODE_POS;
	logic signed [DW-1:0] cur_kp     = '0;
	logic signed [DW-1:0] cur_ki     = '0;
	logic signed [DW-1:0] cur_kd     = '0;
	longint               out_lim    = SAT_HI;
	longint               integ_lim  = SAT_HI;
	longint               err_lim    = 0;
	longint               dead_band  = 0;

	// Controller state that the block keeps from one step to the next.
	longint integ_acc  = 0;
	longint held_drive = 0;
	longint err_last   = 0;
	longint err_prior  = 0;

	// Results still owed by the block, oldest first.
	outcome_t pending_results[$];

	// Traffic shaping: steady turns off all random idling on both sides,
	// hold_off forces a long receiver stall, ready_stall is the per-word draw.
	bit steady      = 1'b0;
	int hold_off    = 0;
	int ready_stall = 0;

	int error_count     = 0;
	int words_sent      = 0;
	int clears_sent     = 0;
	int steps_held_back = 0;
	int results_checked = 0;
	int reg_writes      = 0;
	int phases_run      = 0;
	int longest_stall   = 0;

	pid_position_delta_step dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.measured     (measured),
		.target       (target),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.drive        (drive),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Fixed-point arithmetic of the controller, worked in 64-bit integers.
	// ------------------------------------------------------------------

	function automatic longint sat_word(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Both operands fit in one word, so the full product fits in 64 bits and
	// an arithmetic shift gives the floor of the rescaled value.
	function automatic longint fixed_mul(longint a, longint b);
		longint p;
		p = (a * b) >>> FRAC;
		return sat_word(p);
	endfunction

	// Advance the controller by one word and return the result it produces.
	function automatic outcome_t compute_control_step(pidpd_pkg::action_t act,
		logic signed [DW-1:0] meas, logic signed [DW-1:0] tgt);
		longint   e;
		longint   mag;
		longint   pt;
		longint   it;
		longint   dt;
		outcome_t r;
		if (act == pidpd_pkg::ACT_CLEAR) begin
			integ_acc  = 0;
			held_drive = 0;
			err_last   = 0;
			err_prior  = 0;
			r.drive    = '0;
			r.st       = pidpd_pkg::ST_CLEARED;
			return r;
		end
		e   = sat_word(longint'(tgt) - longint'(meas));
		mag = (e < 0) ? -e : e;
		// A held-back step leaves the state and the error history alone.
		// The error limit is tested before the dead zone.
		if (err_lim != 0 && mag > err_lim) begin
			r.drive = '0;
			r.st    = pidpd_pkg::ST_ERR_LIMIT;
			return r;
		end
		if (dead_band != 0 && mag < dead_band) begin
			r.drive = '0;
			r.st    = pidpd_pkg::ST_DEAD_ZONE;
			return r;
		end
		if (cur_mode == pidpd_pkg::MODE_POS) begin
			pt         = fixed_mul(cur_kp, e);
			integ_acc  = clamp_mag(integ_acc + fixed_mul(cur_ki, e), integ_lim);
			dt         = fixed_mul(cur_kd, sat_word(e - err_last));
			held_drive = clamp_mag(pt + integ_acc + dt, out_lim);
		end else begin
			// The incremental form keeps only this step's clamped integral share.
			pt         = fixed_mul(cur_kp, sat_word(e - err_last));
			it         = clamp_mag(fixed_mul(cur_ki, e), integ_lim);
			integ_acc  = it;
			dt         = fixed_mul(cur_kd, sat_word(e - 2 * err_last + err_prior));
			held_drive = clamp_mag(held_drive + pt + it + dt, out_lim);
		end
		err_prior = err_last;
		err_last  = e;
		r.drive   = held_drive[DW-1:0];
		r.st      = pidpd_pkg::ST_NORMAL;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	task automatic note_failure(string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	// Registers only change while the block is idle, so the expectation can
	// follow the write at once.
	task automatic write_reg(pidpd_pkg::reg_idx_t idx, logic [DW-1:0] val);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		reg_writes++;
		case (idx)
			pidpd_pkg::REG_MODE:           cur_mode  = pidpd_pkg::mode_t'(val[0]);
			pidpd_pkg::REG_GAIN_P:         cur_kp    = val;
			pidpd_pkg::REG_GAIN_I:         cur_ki    = val;
			pidpd_pkg::REG_GAIN_D:         cur_kd    = val;
			pidpd_pkg::REG_OUTPUT_LIMIT:   out_lim   = longint'(val[DW-2:0]);
			pidpd_pkg::REG_INTEGRAL_LIMIT: integ_lim = longint'(val[DW-2:0]);
			pidpd_pkg::REG_ERROR_LIMIT:    err_lim   = longint'(val[DW-2:0]);
			pidpd_pkg::REG_DEAD_ZONE:      dead_band = longint'(val[DW-2:0]);
			default: ;
		endcase
	endtask

	// Offer one word after a random gap, hold it until the block takes it, and
	// only then work out what it should produce.
	task automatic send_word(pidpd_pkg::action_t act, logic signed [DW-1:0] meas,
		logic signed [DW-1:0] tgt);
		int       gap;
		int       waited;
		outcome_t want;
		gap    = steady ? 0 : $urandom_range(0, 6);
		waited = 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		action     = act;
		measured   = meas;
		target     = tgt;
		item_valid = 1'b1;
		@(posedge clk);
		while (!item_ready) begin
			waited++;
			@(posedge clk);
		end
		if (waited > longest_stall) longest_stall = waited;
		want = compute_control_step(act, meas, tgt);
		pending_results.push_back(want);
		words_sent++;
		if (act == pidpd_pkg::ACT_CLEAR) clears_sent++;
		if (want.st == pidpd_pkg::ST_ERR_LIMIT || want.st == pidpd_pkg::ST_DEAD_ZONE) begin
			steps_held_back++;
		end
	endtask

	// Drop valid, wait for every owed result, then let the pipeline settle.
	task automatic wait_idle();
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [DW-1:0] corner_value(int k);
		case (k)
			0:       return WMAX;
			1:       return WMIN;
			2:       return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DW-1:0] random_gain();
		case ($urandom_range(0, 3))
			0:       return int'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
			1:       return $urandom;
			2:       return $urandom_range(0, 1) ? WMAX : WMIN;
			default: return $urandom_range(0, 1) ? ONE : '0;
		endcase
	endfunction

	// Limits sometimes carry a stray top bit, which the block must ignore.
	function automatic logic [DW-1:0] random_limit();
		case ($urandom_range(0, 3))
			0:       return {1'($urandom_range(0, 1)), {(DW-1){1'b1}}};
			1:       return $urandom;
			2:       return $urandom_range(0, 32'h10_0000);
			default: return ($urandom_range(0, 7) == 0) ? '0 : $urandom_range(1, 32'h1_0000);
		endcase
	endfunction

	// Write all eight registers. Kind 1 and 2 are the high and low corners,
	// kind 3 holds back nearly every step, anything else is random.
	task automatic pick_config(int kind);
		pidpd_pkg::mode_t m;
		logic [DW-1:0]    kp;
		logic [DW-1:0]    ki;
		logic [DW-1:0]    kd;
		logic [DW-1:0]    lo;
		logic [DW-1:0]    li;
		logic [DW-1:0]    le;
		logic [DW-1:0]    ld;
		case (kind)
			1: begin
				m  = pidpd_pkg::MODE_INC;
				kp = WMAX;
				ki = WMAX;
				kd = WMAX;
				lo = WMAX;
				li = WMAX;
				le = WMAX;
				ld = 32'd1;
			end
			2: begin
				m  = pidpd_pkg::MODE_POS;
				kp = WMIN;
				ki = WMIN;
				kd = WMIN;
				lo = WMAX;
				li = '0;
				le = '0;
				ld = '0;
			end
			3: begin
				m  = pidpd_pkg::mode_t'($urandom_range(0, 1));
				kp = random_gain();
				ki = random_gain();
				kd = random_gain();
				lo = '0;
				li = random_limit();
				le = '0;
				ld = WMAX;
			end
			default: begin
				m  = pidpd_pkg::mode_t'($urandom_range(0, 1));
				kp = random_gain();
				ki = random_gain();
				kd = random_gain();
				lo = random_limit();
				li = random_limit();
				le = $urandom_range(0, 1) ? '0 : $urandom_range(1, 32'h100_0000);
				ld = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 32'h2000) : '0;
			end
		endcase
		write_reg(pidpd_pkg::REG_MODE, {31'($urandom), m});
		write_reg(pidpd_pkg::REG_GAIN_P, kp);
		write_reg(pidpd_pkg::REG_GAIN_I, ki);
		write_reg(pidpd_pkg::REG_GAIN_D, kd);
		write_reg(pidpd_pkg::REG_OUTPUT_LIMIT, lo);
		write_reg(pidpd_pkg::REG_INTEGRAL_LIMIT, li);
		write_reg(pidpd_pkg::REG_ERROR_LIMIT, le);
		write_reg(pidpd_pkg::REG_DEAD_ZONE, ld);
	endtask

	// A random word. Most are steps whose measurement sits near the target at
	// one of several scales, so the loop state builds up instead of pinning at
	// saturation; the rest are full-range values, corners and clears.
	task automatic random_word();
		pidpd_pkg::action_t   act;
		logic signed [DW-1:0] tgt;
		logic signed [DW-1:0] meas;
		int                   span;
		act = ($urandom_range(0, 29) == 0) ? pidpd_pkg::ACT_CLEAR : pidpd_pkg::ACT_STEP;
		tgt = $urandom;
		case ($urandom_range(0, 5))
			0, 1: span = 32'h800;
			2:    span = 32'h2_0000;
			3:    span = 32'h200_0000;
			default: span = 0;
		endcase
		if (span != 0) begin
			meas = tgt - (int'($urandom_range(0, 2 * span)) - span);
		end else if ($urandom_range(0, 1)) begin
			meas = $urandom;
		end else begin
			tgt  = corner_value($urandom_range(0, 3));
			meas = corner_value($urandom_range(0, 3));
		end
		send_word(act, meas, tgt);
	endtask

	// ------------------------------------------------------------------
	// Result side: ready pattern and checker
	// ------------------------------------------------------------------

	// A long forced hold-off takes priority over the per-word stall.
	initial begin
		result_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				result_ready = 1'b0;
				hold_off--;
			end else if (ready_stall > 0) begin
				result_ready = 1'b0;
				ready_stall--;
			end else begin
				result_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result with nothing owed: drive %0d code %0d",
					drive, status));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (drive !== want.drive || status !== want.st) begin
					note_failure($sformatf("drive exp %0d got %0d, code exp %s got %0d",
						want.drive, drive, want.st.name(), status));
				end
			end
			ready_stall = steady ? 0 : $urandom_range(0, 6);
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// With the reset gains of zero every step must drive zero, even at the
	// widest error.
	task automatic test_reset_defaults();
		send_word(pidpd_pkg::ACT_STEP, WMIN, WMAX);
		send_word(pidpd_pkg::ACT_STEP, WMAX, WMIN);
		wait_idle();
	endtask

	// Positional form: saturated error both ways, a swing from one rail to
	// the other that saturates the difference term, a clear mid-stream.
	task automatic test_positional_steps();
		write_reg(pidpd_pkg::REG_MODE, {31'd0, pidpd_pkg::MODE_POS});
		write_reg(pidpd_pkg::REG_GAIN_P, ONE);
		write_reg(pidpd_pkg::REG_GAIN_I, 32'sh0000_8000);
		write_reg(pidpd_pkg::REG_GAIN_D, 32'sh0000_4000);
		send_word(pidpd_pkg::ACT_STEP, WMIN, WMAX);
		send_word(pidpd_pkg::ACT_STEP, WMAX, WMIN);
		send_word(pidpd_pkg::ACT_STEP, '0, '0);
		send_word(pidpd_pkg::ACT_STEP, 32'sh0002_0000, 32'sh0005_0000);
		send_word(pidpd_pkg::ACT_CLEAR, 32'sh0002_0000, 32'sh0005_0000);
		send_word(pidpd_pkg::ACT_STEP, 32'sh0001_0000, -32'sh0003_0000);
		wait_idle();
	endtask

	// Error limit and dead zone at and around their thresholds, and the case
	// where both apply, in which the error limit wins.
	task automatic test_suppression();
		write_reg(pidpd_pkg::REG_ERROR_LIMIT, 32'h0003_0000);
		write_reg(pidpd_pkg::REG_DEAD_ZONE, 32'h0000_8000);
		send_word(pidpd_pkg::ACT_STEP, '0, 32'sh0003_0000);
		send_word(pidpd_pkg::ACT_STEP, '0, 32'sh0003_0001);
		send_word(pidpd_pkg::ACT_STEP, 32'sh0003_0001, '0);
		send_word(pidpd_pkg::ACT_STEP, '0, 32'sh0000_7FFF);
		send_word(pidpd_pkg::ACT_STEP, '0, 32'sh0000_8000);
		send_word(pidpd_pkg::ACT_STEP, 32'sh0000_7FFF, '0);
		wait_idle();
		write_reg(pidpd_pkg::REG_ERROR_LIMIT, 32'h0000_0100);
		write_reg(pidpd_pkg::REG_DEAD_ZONE, 32'h0000_1000);
		send_word(pidpd_pkg::ACT_STEP, '0, 32'sh0000_0200);
		wait_idle();
	endtask

	// Incremental form with the gains at both rails and tight limits; the
	// alternating rail errors saturate the second difference.
	task automatic test_incremental_extremes();
		write_reg(pidpd_pkg::REG_MODE, {31'd0, pidpd_pkg::MODE_INC});
		write_reg(pidpd_pkg::REG_GAIN_P, WMAX);
		write_reg(pidpd_pkg::REG_GAIN_I, WMIN);
		write_reg(pidpd_pkg::REG_GAIN_D, WMAX);
		write_reg(pidpd_pkg::REG_OUTPUT_LIMIT, 32'h0002_0000);
		write_reg(pidpd_pkg::REG_INTEGRAL_LIMIT, 32'h0001_0000);
		write_reg(pidpd_pkg::REG_ERROR_LIMIT, '0);
		write_reg(pidpd_pkg::REG_DEAD_ZONE, '0);
		send_word(pidpd_pkg::ACT_STEP, WMIN, WMAX);
		send_word(pidpd_pkg::ACT_STEP, WMAX, WMIN);
		send_word(pidpd_pkg::ACT_STEP, WMIN, WMAX);
		send_word(pidpd_pkg::ACT_STEP, WMAX, WMIN);
		send_word(pidpd_pkg::ACT_STEP, '0, '0);
		send_word(pidpd_pkg::ACT_CLEAR, WMAX, WMAX);
		send_word(pidpd_pkg::ACT_STEP, '0, 32'sd1);
		send_word(pidpd_pkg::ACT_STEP, 32'sd1, '0);
		wait_idle();
	endtask

	// Several register settings, corners first, with random words under each.
	task automatic test_random_settings();
		int kind;
		for (int p = 0; p < 9; p++) begin
			kind = (p < 3) ? p + 1 : 0;
			wait_idle();
			pick_config(kind);
			phases_run++;
			repeat (130) random_word();
		end
		wait_idle();
	endtask

	// The receiver stops for a long stretch while words keep coming, so the
	// pipeline and its skid register fill and item_ready must drop.
	task automatic test_back_pressure();
		@(posedge clk);
		hold_off = 80;
		steady   = 1'b1;
		repeat (40) random_word();
		steady = 1'b0;
		wait_idle();
	endtask

	// Full-rate stream with no idling on either side.
	task automatic test_steady_stream();
		pick_config(0);
		phases_run++;
		steady = 1'b1;
		repeat (120) random_word();
		steady = 1'b0;
		wait_idle();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_wen    = 1'b0;
		cfg_idx    = pidpd_pkg::REG_MODE;
		cfg_wdata  = '0;
		item_valid = 1'b0;
		action     = pidpd_pkg::ACT_STEP;
		measured   = '0;
		target     = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_positional_steps();
		test_suppression();
		test_incremental_extremes();
		test_random_settings();
		test_back_pressure();
		test_steady_stream();

		wait_idle();
		if (pending_results.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", pending_results.size()));
		end
		$display("Covered %0d words (%0d clears, %0d held-back steps), %0d results checked.",
			words_sent, clears_sent, steps_held_back, results_checked);
		$display("%0d register writes over %0d random settings; longest input stall %0d cycles.",
			reg_writes, phases_run, longest_stall);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d failures", error_count);
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("run did not finish in time");
		$display("status: fail");
		$finish;
	end

endmodule
